// ----- src/qsmc_pkg.sv -----
// Package for the quadratic spline maximum curvature block: widths, codes, stage types
// and small helper functions. No dependencies.
package qsmc_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIMS       = 3;

	localparam int OUT_W  = 32;
	localparam int QUO_W  = 2 * OUT_W;
	localparam int LIMB_W = 32;
	localparam int PROD_W = 2 * LIMB_W;

	// |u|, |v| < 2^COORD_BITS and |u+v| < 2^(COORD_BITS+1)
	localparam int DIF_W = COORD_BITS + 2;
	localparam int MAG_W = COORD_BITS + 1;
	localparam int PR_W  = 2 * MAG_W;
	// sum of three squares
	localparam int SQ_W  = PR_W + 2;
	localparam int SE_W  = SQ_W + 1;
	localparam int CR_W  = 2 * SQ_W;
	localparam int X3_W  = 3 * SQ_W;
	localparam int C4_W  = 2 * CR_W;
	localparam int PP_W  = CR_W + LIMB_W;

	localparam int NUM_SHIFT = 4 * FRAC_BITS;
	localparam int NUM_W = ((CR_W > X3_W) ? CR_W : X3_W) + NUM_SHIFT;
	localparam int DEN_W = (X3_W > C4_W) ? X3_W : C4_W;
	localparam int CMP_W = DEN_W + QUO_W;
	localparam int SR_W  = QUO_W + 1;

	localparam int NL_SQ = (SQ_W + LIMB_W - 1) / LIMB_W;
	localparam int NL_CR = (CR_W + LIMB_W - 1) / LIMB_W;
	localparam int MUL_STAGES = ((NL_SQ + 1 + NL_CR) > (2 * NL_SQ)) ?
		(NL_SQ + 1 + NL_CR) : (2 * NL_SQ);

	localparam logic [1:0] CASE_START = 2'd0;
	localparam logic [1:0] CASE_END   = 2'd1;
	localparam logic [1:0] CASE_MID   = 2'd2;

	typedef struct packed {
		logic [1:0] which;
		logic       den_zero;
		logic       area_zero;
	} ctl_t;

	typedef struct packed {
		ctl_t            ctl;
		logic [SQ_W-1:0] su;
		logic [SQ_W-1:0] sv;
		logic [SQ_W-1:0] diff;
		logic [SQ_W-1:0] x;
		logic [CR_W-1:0] a1;
		logic [CR_W-1:0] a2;
		logic [CR_W-1:0] cross2;
		logic [CR_W-1:0] x2;
		logic [X3_W-1:0] x3;
		logic [C4_W-1:0] c4;
	} mul_t;

	typedef struct packed {
		ctl_t             ctl;
		logic             sat;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] q;
	} div_t;

	typedef struct packed {
		ctl_t             ctl;
		logic             sat;
		logic [SR_W-1:0]  rem;
		logic [OUT_W-1:0] r;
	} sqr_t;

	typedef struct packed {
		logic [OUT_W-1:0] curvature;
		logic             unbounded;
		logic             saturated;
		logic [1:0]       which;
	} res_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [DIF_W-1:0] x);
		mag = MAG_W'(x[DIF_W-1] ? -x : x);
	endfunction

	function automatic logic [LIMB_W-1:0] limb_of(input logic [CR_W-1:0] v, input int k);
		limb_of = LIMB_W'(v >> (LIMB_W * k));
	endfunction

	// wide value times one limb from limb-by-limb products; even and odd partial
	// products never overlap, so each set sits side by side and one add joins them
	function automatic logic [PP_W-1:0] mul_limb(input logic [CR_W-1:0] v,
		input logic [LIMB_W-1:0] l);
		logic [PP_W-1:0]   ev;
		logic [PP_W-1:0]   od;
		logic [PROD_W-1:0] p;
		ev = '0;
		od = '0;
		for (int k = 0; k < NL_CR; k++) begin
			p = PROD_W'(limb_of(v, k)) * PROD_W'(l);
			if ((k & 1) == 0) begin
				ev = ev | (PP_W'(p) << (LIMB_W * k));
			end else begin
				od = od | (PP_W'(p) << (LIMB_W * k));
			end
		end
		mul_limb = ev + od;
	endfunction

endpackage

// ----- src/qsmc_seg_if.sv -----
// Input channel: one spline segment (three control points and the 2D/3D mode).
// Depends on qsmc_pkg.
interface qsmc_seg_if import qsmc_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         is_three_d;
	logic signed [COORD_BITS-1:0] ctrl_x0;
	logic signed [COORD_BITS-1:0] ctrl_x1;
	logic signed [COORD_BITS-1:0] ctrl_x2;
	logic signed [COORD_BITS-1:0] ctrl_y0;
	logic signed [COORD_BITS-1:0] ctrl_y1;
	logic signed [COORD_BITS-1:0] ctrl_y2;
	logic signed [COORD_BITS-1:0] ctrl_z0;
	logic signed [COORD_BITS-1:0] ctrl_z1;
	logic signed [COORD_BITS-1:0] ctrl_z2;

	modport source (output valid, is_three_d, ctrl_x0, ctrl_x1, ctrl_x2, ctrl_y0, ctrl_y1,
		ctrl_y2, ctrl_z0, ctrl_z1, ctrl_z2, input ready);
	modport sink (input valid, is_three_d, ctrl_x0, ctrl_x1, ctrl_x2, ctrl_y0, ctrl_y1,
		ctrl_y2, ctrl_z0, ctrl_z1, ctrl_z2, output ready);
endinterface

// ----- src/qsmc_res_if.sv -----
// Output channel: maximum curvature of one segment with its flags.
// Depends on qsmc_pkg.
interface qsmc_res_if import qsmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] curvature;
	logic             unbounded;
	logic             saturated;
	logic [1:0]       case_taken;

	modport source (output valid, curvature, unbounded, saturated, case_taken, input ready);
	modport sink (input valid, curvature, unbounded, saturated, case_taken, output ready);
endinterface

// ----- src/qsmc_root.sv -----
// Pipelined floor(sqrt(num / den)) with saturation, one item per cycle while adv is high.
// Restoring division one quotient bit a stage, then a restoring square root. Uses qsmc_pkg.
module qsmc_root import qsmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  ctl_t             ctl,
	output logic             out_valid,
	output res_t             out
);

	div_t             div_s [QUO_W+1];
	div_t             div_nx [QUO_W+1];
	sqr_t             sqr_s [OUT_W];
	sqr_t             sqr_nx [OUT_W];
	sqr_t             sqr_chain [OUT_W];
	res_t             res_s;
	res_t             res_nx;
	logic [QUO_W:0]   div_v_s;
	logic [OUT_W-1:0] sqr_v_s;
	logic             res_v_s;

	// saturation check (quotient of 2^QUO_W or more), then one quotient bit a stage,
	// most significant first
	always_comb begin
		logic [CMP_W-1:0] t;
		div_nx[0].ctl = ctl;
		div_nx[0].sat = (CMP_W'(den) << QUO_W) <= CMP_W'(num);
		div_nx[0].rem = num;
		div_nx[0].den = den;
		div_nx[0].q   = '0;
		for (int k = 0; k < QUO_W; k++) begin
			div_nx[k+1] = div_s[k];
			t = CMP_W'(div_s[k].den) << (QUO_W - 1 - k);
			if (!div_s[k].sat && t <= CMP_W'(div_s[k].rem)) begin
				div_nx[k+1].rem = div_s[k].rem - NUM_W'(t);
				div_nx[k+1].q[QUO_W-1-k] = 1'b1;
			end
		end
	end

	// one root bit a stage; rem holds quotient minus root squared
	always_comb begin
		logic [SR_W-1:0] t;
		sqr_chain[0].ctl = div_s[QUO_W].ctl;
		sqr_chain[0].sat = div_s[QUO_W].sat;
		sqr_chain[0].rem = SR_W'(div_s[QUO_W].q);
		sqr_chain[0].r   = '0;
		for (int k = 1; k < OUT_W; k++) begin
			sqr_chain[k] = sqr_s[k-1];
		end
		for (int k = 0; k < OUT_W; k++) begin
			sqr_nx[k] = sqr_chain[k];
			t = (SR_W'(sqr_chain[k].r) << (OUT_W - k)) | (SR_W'(1) << (2 * (OUT_W - 1 - k)));
			if (t <= sqr_chain[k].rem) begin
				sqr_nx[k].rem = sqr_chain[k].rem - t;
				sqr_nx[k].r[OUT_W-1-k] = 1'b1;
			end
		end
	end

	always_comb begin
		res_nx.which     = sqr_s[OUT_W-1].ctl.which;
		res_nx.unbounded = 1'b0;
		res_nx.saturated = 1'b0;
		res_nx.curvature = sqr_s[OUT_W-1].r;
		if (sqr_s[OUT_W-1].ctl.den_zero) begin
			res_nx.curvature = '0;
		end else if (sqr_s[OUT_W-1].ctl.area_zero) begin
			res_nx.curvature = {OUT_W{1'b1}};
			res_nx.unbounded = 1'b1;
		end else if (sqr_s[OUT_W-1].sat) begin
			res_nx.curvature = {OUT_W{1'b1}};
			res_nx.saturated = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s <= '0;
			sqr_v_s <= '0;
			res_v_s <= 1'b0;
		end else if (adv) begin
			div_v_s <= {div_v_s[QUO_W-1:0], in_valid};
			sqr_v_s <= {sqr_v_s[OUT_W-2:0], div_v_s[QUO_W]};
			res_v_s <= sqr_v_s[OUT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= QUO_W; k++) begin
				div_s[k] <= div_nx[k];
			end
			for (int k = 0; k < OUT_W; k++) begin
				sqr_s[k] <= sqr_nx[k];
			end
			res_s <= res_nx;
		end
	end

	assign out_valid = res_v_s;
	assign out       = res_s;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s |-> !(res_s.unbounded && res_s.saturated))
		else $error("unbounded and saturated both set");

endmodule

// ----- src/quadratic_spline_max_curvature.sv -----
// Maximum curvature of a quadratic uniform B-spline segment, fully pipelined.
// Depends on qsmc_pkg, qsmc_seg_if, qsmc_res_if and qsmc_root.
//
// The block takes one segment (three signed Q16.16 control points, 2D or 3D) per cycle and
// returns its maximum curvature as unsigned Q16.16, truncated toward zero, exactly. In order:
// 4 stages form the legs, squared lengths, dot products and the case decision,
// 9 stages run the wide products (32-bit limb of one operand per stage), 1 stage selects
// numerator and denominator, then 1 saturation check, 64 division stages (one quotient bit
// each), 32 square root stages (one root bit each) and the output register. Throughput is
// one item per cycle. The whole pipeline holds while a result waits on res.ready, so
// seg.ready is low exactly when the output register is full and not taken.
// case_taken tells which point carries the maximum: start, end or interior. An endpoint
// case with a zero-length leg gives 0; an interior case with zero area gives all ones with
// unbounded set; a finite value of 2^32 or more gives all ones with saturated set.
module quadratic_spline_max_curvature import qsmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	qsmc_seg_if.sink   seg,
	qsmc_res_if.source res
);

	logic adv;

	logic signed [COORD_BITS-1:0] pa [DIMS];
	logic signed [COORD_BITS-1:0] pb [DIMS];
	logic signed [COORD_BITS-1:0] pc [DIMS];
	logic signed [DIF_W-1:0]      du [DIMS];
	logic signed [DIF_W-1:0]      dv [DIMS];
	logic signed [DIF_W-1:0]      dw [DIMS];

	// stage 1: leg magnitudes
	logic [MAG_W-1:0] mu_s1 [DIMS];
	logic [MAG_W-1:0] mv_s1 [DIMS];
	logic [MAG_W-1:0] mw_s1 [DIMS];
	logic [DIMS-1:0]  ng_s1;
	logic             v_s1;
	// stage 2: per-axis products
	logic [PR_W-1:0]  squ_s2 [DIMS];
	logic [PR_W-1:0]  sqv_s2 [DIMS];
	logic [PR_W-1:0]  sqw_s2 [DIMS];
	logic [PR_W-1:0]  uv_s2  [DIMS];
	logic [DIMS-1:0]  ng_s2;
	logic             v_s2;
	// stage 3: sums
	logic [SQ_W-1:0]  su_n, sv_n, sm_n, pos_n, neg_n;
	logic [SQ_W-1:0]  su_s3, sv_s3, sm_s3, pos_s3, neg_s3;
	logic             v_s3;
	// stage 4: case decision
	logic             c_start, c_end;
	mul_t             mul_in;
	mul_t             in_s4;
	logic             v_s4;
	// wide products
	mul_t             mul_chain [MUL_STAGES];
	mul_t             mul_nx [MUL_STAGES];
	mul_t             mul_s [MUL_STAGES];
	logic [MUL_STAGES-1:0] mul_v_s;
	// operand selection for the root
	logic [NUM_W-1:0] num_n, num_s5;
	logic [DEN_W-1:0] den_n, den_s5;
	ctl_t             ctl_n, ctl_s5;
	logic             v_s5;

	logic             out_valid;
	res_t             out;

	// advance everything unless a result is held
	assign adv       = !out_valid || res.ready;
	assign seg.ready = adv;

	assign pa[0] = seg.ctrl_x0;
	assign pb[0] = seg.ctrl_x1;
	assign pc[0] = seg.ctrl_x2;
	assign pa[1] = seg.ctrl_y0;
	assign pb[1] = seg.ctrl_y1;
	assign pc[1] = seg.ctrl_y2;
	// drop z in 2D mode
	assign pa[2] = seg.is_three_d ? seg.ctrl_z0 : '0;
	assign pb[2] = seg.is_three_d ? seg.ctrl_z1 : '0;
	assign pc[2] = seg.is_three_d ? seg.ctrl_z2 : '0;

	// u = c1 - c0, v = c1 - c2, w = u + v
	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			du[d] = DIF_W'(pb[d]) - DIF_W'(pa[d]);
			dv[d] = DIF_W'(pb[d]) - DIF_W'(pc[d]);
			dw[d] = du[d] + dv[d];
		end
	end

	// sums of squares; u.v split by sign so both parts stay unsigned
	always_comb begin
		su_n  = '0;
		sv_n  = '0;
		sm_n  = '0;
		pos_n = '0;
		neg_n = '0;
		for (int d = 0; d < DIMS; d++) begin
			su_n = su_n + SQ_W'(squ_s2[d]);
			sv_n = sv_n + SQ_W'(sqv_s2[d]);
			sm_n = sm_n + SQ_W'(sqw_s2[d]);
			if (ng_s2[d]) begin
				neg_n = neg_n + SQ_W'(uv_s2[d]);
			end else begin
				pos_n = pos_n + SQ_W'(uv_s2[d]);
			end
		end
	end

	// start wins when start.mid <= 0, else end when mid.end <= 0, else interior
	always_comb begin
		c_start = (SE_W'(su_s3) + SE_W'(pos_s3)) <= SE_W'(neg_s3);
		c_end   = (SE_W'(sv_s3) + SE_W'(pos_s3)) <= SE_W'(neg_s3);
		mul_in        = '0;
		mul_in.su     = su_s3;
		mul_in.sv     = sv_s3;
		mul_in.diff   = (pos_s3 >= neg_s3) ? (pos_s3 - neg_s3) : (neg_s3 - pos_s3);
		if (c_start) begin
			mul_in.ctl.which    = CASE_START;
			mul_in.ctl.den_zero = (su_s3 == '0);
			mul_in.x            = su_s3;
		end else if (c_end) begin
			mul_in.ctl.which    = CASE_END;
			mul_in.ctl.den_zero = (sv_s3 == '0);
			mul_in.x            = sv_s3;
		end else begin
			mul_in.ctl.which    = CASE_MID;
			mul_in.x            = sm_s3;
		end
	end

	// Wide products, one 32-bit limb of the second operand per stage:
	// cross2 = su*sv - diff^2, then cross2^2, and x^2 then x^3 alongside.
	always_comb begin
		int kx3;
		int kc4;
		mul_chain[0] = in_s4;
		for (int j = 1; j < MUL_STAGES; j++) begin
			mul_chain[j] = mul_s[j-1];
		end
		for (int j = 0; j < MUL_STAGES; j++) begin
			kx3 = (j >= NL_SQ) ? (j - NL_SQ) : 0;
			kc4 = (j > NL_SQ) ? (j - NL_SQ - 1) : 0;
			mul_nx[j] = mul_chain[j];
			if (j < NL_SQ) begin
				mul_nx[j].a1 = mul_chain[j].a1 + (CR_W'(mul_limb(CR_W'(mul_chain[j].su),
					limb_of(CR_W'(mul_chain[j].sv), j))) << (LIMB_W * j));
				mul_nx[j].a2 = mul_chain[j].a2 + (CR_W'(mul_limb(CR_W'(mul_chain[j].diff),
					limb_of(CR_W'(mul_chain[j].diff), j))) << (LIMB_W * j));
				mul_nx[j].x2 = mul_chain[j].x2 + (CR_W'(mul_limb(CR_W'(mul_chain[j].x),
					limb_of(CR_W'(mul_chain[j].x), j))) << (LIMB_W * j));
			end
			if (j == NL_SQ) begin
				mul_nx[j].cross2 = mul_chain[j].a1 - mul_chain[j].a2;
			end
			if (j >= NL_SQ && j < 2 * NL_SQ) begin
				mul_nx[j].x3 = mul_chain[j].x3 + (X3_W'(mul_limb(mul_chain[j].x2,
					limb_of(CR_W'(mul_chain[j].x), kx3))) << (LIMB_W * kx3));
			end
			if (j > NL_SQ && j <= NL_SQ + NL_CR) begin
				mul_nx[j].c4 = mul_chain[j].c4 + (C4_W'(mul_limb(mul_chain[j].cross2,
					limb_of(mul_chain[j].cross2, kc4))) << (LIMB_W * kc4));
			end
		end
	end

	// endpoint: cross2*2^4F / |leg|^6 ; interior: |mid|^6*2^4F / cross2^2
	always_comb begin
		ctl_n = mul_s[MUL_STAGES-1].ctl;
		ctl_n.area_zero = (mul_s[MUL_STAGES-1].ctl.which == CASE_MID) &&
			(mul_s[MUL_STAGES-1].cross2 == '0);
		if (mul_s[MUL_STAGES-1].ctl.which == CASE_MID) begin
			num_n = NUM_W'(mul_s[MUL_STAGES-1].x3) << NUM_SHIFT;
			den_n = DEN_W'(mul_s[MUL_STAGES-1].c4);
		end else begin
			num_n = NUM_W'(mul_s[MUL_STAGES-1].cross2) << NUM_SHIFT;
			den_n = DEN_W'(mul_s[MUL_STAGES-1].x3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			mul_v_s <= '0;
			v_s5    <= 1'b0;
		end else if (adv) begin
			v_s1    <= seg.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			mul_v_s <= {mul_v_s[MUL_STAGES-2:0], v_s4};
			v_s5    <= mul_v_s[MUL_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < DIMS; d++) begin
				mu_s1[d]  <= mag(du[d]);
				mv_s1[d]  <= mag(dv[d]);
				mw_s1[d]  <= mag(dw[d]);
				ng_s1[d]  <= du[d][DIF_W-1] ^ dv[d][DIF_W-1];
				squ_s2[d] <= PR_W'(mu_s1[d]) * PR_W'(mu_s1[d]);
				sqv_s2[d] <= PR_W'(mv_s1[d]) * PR_W'(mv_s1[d]);
				sqw_s2[d] <= PR_W'(mw_s1[d]) * PR_W'(mw_s1[d]);
				uv_s2[d]  <= PR_W'(mu_s1[d]) * PR_W'(mv_s1[d]);
			end
			ng_s2  <= ng_s1;
			su_s3  <= su_n;
			sv_s3  <= sv_n;
			sm_s3  <= sm_n;
			pos_s3 <= pos_n;
			neg_s3 <= neg_n;
			in_s4  <= mul_in;
			for (int j = 0; j < MUL_STAGES; j++) begin
				mul_s[j] <= mul_nx[j];
			end
			num_s5 <= num_n;
			den_s5 <= den_n;
			ctl_s5 <= ctl_n;
		end
	end

	qsmc_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s5),
		.num      (num_s5),
		.den      (den_s5),
		.ctl      (ctl_s5),
		.out_valid(out_valid),
		.out      (out)
	);

	assign res.valid      = out_valid;
	assign res.curvature  = out.curvature;
	assign res.unbounded  = out.unbounded;
	assign res.saturated  = out.saturated;
	assign res.case_taken = out.which;

	a_unb_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.unbounded |->
			res.case_taken == CASE_MID && res.curvature == {OUT_W{1'b1}})
		else $error("unbounded result outside interior case or not all ones");

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.saturated |-> res.curvature == {OUT_W{1'b1}})
		else $error("saturated result not all ones");

	a_zero_leg_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && ctl_s5.den_zero |-> ctl_s5.which != CASE_MID && !ctl_s5.area_zero)
		else $error("zero leg flagged in interior case");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready |=> v_s1)
		else $error("accepted item lost at first stage");

endmodule

// ----- tb/quadratic_spline_max_curvature_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_spline_max_curvature: directed and random segments,
// exact wide-integer prediction, random idling on both channels.
// Depends on qsmc_pkg, qsmc_seg_if, qsmc_res_if and the block itself.
module quadratic_spline_max_curvature_test;
	import qsmc_pkg::*;

	localparam int BIG_W = 512;
	localparam int PIPE_LAT = 112;
	localparam int STALL_LIMIT = 5000;

	// One segment: coord[axis][point], axis 0=x 1=y 2=z.
	typedef struct packed {
		logic                               three_d;
		logic [2:0][2:0][COORD_BITS-1:0] coord;
	} segment_t;

	// Largest q below 2^32 with q^2*den <= num; flag the value when it reaches 2^32.
	function automatic logic [OUT_W-1:0] root_of_ratio(input logic [BIG_W-1:0] num,
		input logic [BIG_W-1:0] den, output logic sat);
		logic [BIG_W-1:0] q;
		logic [BIG_W-1:0] cand;
		q = '0;
		sat = 1'b0;
		if ((den << 64) <= num) begin
			sat = 1'b1;
			return '1;
		end
		for (int b = 31; b >= 0; b--) begin
			cand = q | (BIG_W'(1) << b);
			if (cand * cand * den <= num)
				q = cand;
		end
		return q[OUT_W-1:0];
	endfunction

	function automatic res_t predict_curvature(input segment_t s);
		logic [BIG_W-1:0] su, sv, sm, pos, neg, diff, cross2;
		logic signed [35:0] a, b, c, u, v, w;
		logic [35:0] mu, mv, mw;
		logic sat;
		int dims;
		res_t r;
		su = '0; sv = '0; sm = '0; pos = '0; neg = '0;
		sat = 1'b0;
		dims = s.three_d ? 3 : 2;
		for (int d = 0; d < dims; d++) begin
			a = $signed(s.coord[d][0]);
			b = $signed(s.coord[d][1]);
			c = $signed(s.coord[d][2]);
			u = b - a;
			v = b - c;
			w = u + v;
			mu = u[35] ? -u : u;
			mv = v[35] ? -v : v;
			mw = w[35] ? -w : w;
			su = su + BIG_W'(mu) * BIG_W'(mu);
			sv = sv + BIG_W'(mv) * BIG_W'(mv);
			sm = sm + BIG_W'(mw) * BIG_W'(mw);
			if (u[35] ^ v[35])
				neg = neg + BIG_W'(mu) * BIG_W'(mv);
			else
				pos = pos + BIG_W'(mu) * BIG_W'(mv);
		end
		diff = (pos >= neg) ? pos - neg : neg - pos;
		cross2 = su * sv - diff * diff;
		r.curvature = '0;
		r.unbounded = 1'b0;
		r.saturated = 1'b0;
		if (su + pos <= neg) begin
			r.which = CASE_START;
			if (su != 0)
				r.curvature = root_of_ratio(cross2 << (4 * FRAC_BITS), su * su * su, sat);
		end else if (sv + pos <= neg) begin
			r.which = CASE_END;
			if (sv != 0)
				r.curvature = root_of_ratio(cross2 << (4 * FRAC_BITS), sv * sv * sv, sat);
		end else begin
			r.which = CASE_MID;
			// collinear legs pointing the same way: the turn is a cusp
			if (cross2 == 0) begin
				r.unbounded = 1'b1;
				r.curvature = '1;
			end else
				r.curvature = root_of_ratio((sm * sm * sm) << (4 * FRAC_BITS),
					cross2 * cross2, sat);
		end
		r.saturated = sat;
		return r;
	endfunction

	// Scoreboard: predict on each accepted segment, compare each accepted result in order.
	class curvature_board;
		res_t pending[$];
		int mismatches;
		int checked;
		int per_case[3];
		int unbounded_seen;
		int saturated_seen;

		function void note_segment(segment_t s);
			pending.push_back(predict_curvature(s));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: curvature %h unb %b sat %b case %0d",
						got.curvature, got.unbounded, got.saturated, got.which);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.which <= CASE_MID)
				per_case[want.which]++;
			if (want.unbounded)
				unbounded_seen++;
			if (want.saturated)
				saturated_seen++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch #%0d: expected curv %h unb %b sat %b case %0d",
						checked, want.curvature, want.unbounded, want.saturated, want.which);
					$display("    got curv %h unb %b sat %b case %0d",
						got.curvature, got.unbounded, got.saturated, got.which);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	qsmc_seg_if seg();
	qsmc_res_if res();

	quadratic_spline_max_curvature dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg.sink),
		.res(res.source)
	);

	curvature_board board;
	int sender_idle_pct;
	int receiver_stall_pct;
	int quiet_cycles = 0;
	int sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at the rate of the current phase.
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Monitor both channels at the edge; values read here are the pre-edge ones.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (seg.valid && seg.ready)
				board.note_segment({seg.is_three_d,
					seg.ctrl_z2, seg.ctrl_z1, seg.ctrl_z0,
					seg.ctrl_y2, seg.ctrl_y1, seg.ctrl_y0,
					seg.ctrl_x2, seg.ctrl_x1, seg.ctrl_x0});
			if (res.valid && res.ready) begin
				got.curvature = res.curvature;
				got.unbounded = res.unbounded;
				got.saturated = res.saturated;
				got.which = res.case_taken;
				board.check_result(got);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((seg.valid && seg.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("** quadratic_spline_max_curvature: FAILED **");
			$finish;
		end
	end

	// Present one segment and hold it until accepted; idle first at the phase rate.
	task automatic send_segment(input segment_t s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg.valid <= 1'b1;
		seg.is_three_d <= s.three_d;
		seg.ctrl_x0 <= s.coord[0][0];
		seg.ctrl_x1 <= s.coord[0][1];
		seg.ctrl_x2 <= s.coord[0][2];
		seg.ctrl_y0 <= s.coord[1][0];
		seg.ctrl_y1 <= s.coord[1][1];
		seg.ctrl_y2 <= s.coord[1][2];
		seg.ctrl_z0 <= s.coord[2][0];
		seg.ctrl_z1 <= s.coord[2][1];
		seg.ctrl_z2 <= s.coord[2][2];
		do
			@(posedge clk);
		while (!seg.ready);
		sent++;
	endtask

	function automatic logic [COORD_BITS-1:0] spread(input int lim);
		return COORD_BITS'($signed($urandom_range(2 * lim)) - lim);
	endfunction

	// Random segment; four kinds in ten are shaped to reach the cusp, zero-leg and saturating corners.
	function automatic segment_t random_segment();
		segment_t s;
		int kind;
		int k;
		logic [COORD_BITS-1:0] d;
		s.three_d = 1'($urandom_range(1));
		kind = $urandom_range(9);
		for (int ax = 0; ax < 3; ax++)
			for (int p = 0; p < 3; p++)
				s.coord[ax][p] = (kind <= 2) ? $urandom() : spread(1 << 20);
		case (kind)
			3: begin
				// tiny segment with a sharp turn: curvature overflows
				for (int ax = 0; ax < 3; ax++)
					for (int p = 0; p < 3; p++)
						s.coord[ax][p] = spread(8);
			end
			4, 5: begin
				// collinear legs; same direction gives a cusp, opposite an endpoint max
				k = $urandom_range(1, 4);
				for (int ax = 0; ax < 3; ax++) begin
					d = spread(1 << 14);
					s.coord[ax][1] = spread(1 << 28);
					s.coord[ax][0] = s.coord[ax][1] - d;
					s.coord[ax][2] = (kind == 4) ? s.coord[ax][1] - k * d
						: s.coord[ax][1] + k * d;
				end
			end
			6: begin
				// zero-length start or end leg
				k = $urandom_range(1) ? 0 : 2;
				for (int ax = 0; ax < 3; ax++)
					s.coord[ax][k] = s.coord[ax][1];
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic segment_t make_segment(input logic three_d,
		input logic [COORD_BITS-1:0] x0, x1, x2, y0, y1, y2, z0, z1, z2);
		segment_t s;
		s.three_d = three_d;
		s.coord = {z2, z1, z0, y2, y1, y0, x2, x1, x0};
		return s;
	endfunction

	initial begin
		localparam logic [COORD_BITS-1:0] MAXC = {1'b0, {(COORD_BITS-1){1'b1}}};
		localparam logic [COORD_BITS-1:0] MINC = {1'b1, {(COORD_BITS-1){1'b0}}};
		localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FRAC_BITS;
		segment_t directed[$];
		int phase_idle[4];
		int phase_stall[4];
		int waited;
		board = new();
		phase_idle = '{0, 68, 0, 18};
		phase_stall = '{0, 0, 68, 18};
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		sent = 0;
		seg.valid = 1'b0;
		seg.is_three_d = 1'b0;
		{seg.ctrl_x0, seg.ctrl_x1, seg.ctrl_x2, seg.ctrl_y0, seg.ctrl_y1, seg.ctrl_y2,
			seg.ctrl_z0, seg.ctrl_z1, seg.ctrl_z2} = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all points coincident: zero start leg
		directed.push_back(make_segment(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_segment(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// coordinate extremes
		directed.push_back(make_segment(1'b1, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC,
			MINC));
		directed.push_back(make_segment(1'b1, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC,
			MAXC));
		directed.push_back(make_segment(1'b0, MINC, MAXC, MAXC, MINC, MINC, MAXC, 0, 0, 0));
		directed.push_back(make_segment(1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		directed.push_back(make_segment(1'b1, MINC, 0, MAXC, 0, MAXC, 0, MAXC, MINC, 0));
		// right angle at unit scale: interior maximum
		directed.push_back(make_segment(1'b0, 0, ONE, ONE, 0, 0, ONE, 0, 0, 0));
		// 2D mode with z garbage must ignore z
		directed.push_back(make_segment(1'b0, 0, ONE, ONE, 0, 0, ONE, MAXC, MINC, '1));
		// cusp: c0 == c2, legs collinear and aligned
		directed.push_back(make_segment(1'b0, 0, ONE, 0, 0, ONE, 0, 0, 0, 0));
		directed.push_back(make_segment(1'b1, ONE, 0, ONE, 5, 7, 5, MINC, 0, MINC));
		// straight line through: endpoint with zero area
		directed.push_back(make_segment(1'b0, 0, ONE, 2 * ONE, 0, ONE, 2 * ONE, 0, 0, 0));
		// zero end leg, nonzero start leg
		directed.push_back(make_segment(1'b0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0));
		// zero start leg, nonzero end leg
		directed.push_back(make_segment(1'b1, ONE, ONE, 0, 3, 3, 0, 9, 9, 1));
		// obtuse legs: start and end maxima
		directed.push_back(make_segment(1'b0, 0, ONE, 4 * ONE, 0, 0, ONE, 0, 0, 0));
		directed.push_back(make_segment(1'b0, 4 * ONE, ONE, 0, ONE, 0, 0, 0, 0, 0));
		// smallest steps: saturating curvature
		directed.push_back(make_segment(1'b0, 0, 1, 1, 0, 0, 1, 0, 0, 0));
		directed.push_back(make_segment(1'b1, 0, 1, 0, 1, 0, 0, 0, 0, 1));
		directed.push_back(make_segment(1'b1, 1, 0, 0, 0, 0, 0, 0, 1, 0));
		foreach (directed[i])
			send_segment(directed[i]);

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = phase_idle[ph];
			receiver_stall_pct = phase_stall[ph];
			for (int n = 0; n < 258; n++)
				send_segment(random_segment());
		end
		seg.valid <= 1'b0;
		receiver_stall_pct = 0;

		// drain, then wait in quiet to catch stray results
		waited = 0;
		while (board.pending.size() != 0 && waited < 50 * PIPE_LAT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (board.pending.size() != 0) begin
			board.mismatches++;
			$display("%0d results never arrived", board.pending.size());
		end

		$display("covered %0d segments: %0d start, %0d end, %0d interior maxima",
			sent, board.per_case[0], board.per_case[1], board.per_case[2]);
		$display("  with %0d unbounded and %0d saturated results, %0d mismatches",
			board.unbounded_seen, board.saturated_seen, board.mismatches);
		if (board.mismatches == 0)
			$display("** quadratic_spline_max_curvature: PASSED **");
		else
			$display("** quadratic_spline_max_curvature: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
src/qsmc_pkg.sv
src/qsmc_seg_if.sv
src/qsmc_res_if.sv
src/qsmc_root.sv
src/quadratic_spline_max_curvature.sv
tb/quadratic_spline_max_curvature_test.sv
